// File: rtl/b64e_pkg.sv
// Shared types, constants and character lookup for the base64 stream encoder.
package b64e_pkg;

    // ASCII code of the padding character
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Number of input bytes in one full group
    localparam logic [1:0] GROUP_BYTES = 2'd3;

    // Index of the last character of a group
    localparam logic [1:0] LAST_CHAR_IDX = 2'd3;

    // One group of up to three bytes, queued between the front and back parts
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;     // bytes that carry data, 1..3
        logic       last_group; // group closes the message
    } group_t;

    // Map a 6-bit value onto the standard base64 alphabet
    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        begin
            if (v < 6'd26)
            begin
                c = {2'b00, v} + 8'd65;
            end
            else if (v < 6'd52)
            begin
                c = {2'b00, v} + 8'd71;
            end
            else if (v < 6'd62)
            begin
                c = {2'b00, v} - 8'd4;
            end
            else if (v == 6'd62)
            begin
                c = 8'h2B;
            end
            else
            begin
                c = 8'h2F;
            end
            return c;
        end
    endfunction

endpackage

// File: rtl/b64e_front.sv
// Front part: collects input bytes into groups of three and hands them on.
module b64e_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // is_final
    input  logic               q_full,
    output logic               q_push,
    output b64e_pkg::group_t   q_group
);

    logic [7:0] pend0_reg;
    logic [7:0] pend0_next;
    logic [7:0] pend1_reg;
    logic [7:0] pend1_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       accept;
    logic       close_group;
    logic       two_held;

    // Take a request whenever the queue has room
    assign s_tready    = !q_full;
    assign accept      = s_tvalid && s_tready;
    assign two_held    = (cnt_reg >= 2'd2);
    assign close_group = two_held || s_tlast;
    assign q_push      = accept && close_group;

    // Assemble the group from held bytes and the new byte
    always_comb
    begin
        q_group.b0         = (cnt_reg != 2'd0) ? pend0_reg : s_tdata;
        q_group.b1         = two_held ? pend1_reg :
                             ((cnt_reg == 2'd1) ? s_tdata : 8'd0);
        q_group.b2         = two_held ? s_tdata : 8'd0;
        q_group.nbytes     = two_held ? b64e_pkg::GROUP_BYTES : (cnt_reg + 2'd1);
        q_group.last_group = s_tlast;
    end

    // Hold a byte or clear the pending state once a group leaves
    always_comb
    begin
        pend0_next = pend0_reg;
        pend1_next = pend1_reg;
        cnt_next   = cnt_reg;
        if (accept)
        begin
            if (close_group)
            begin
                pend0_next = 8'd0;
                pend1_next = 8'd0;
                cnt_next   = 2'd0;
            end
            else if (cnt_reg == 2'd0)
            begin
                pend0_next = s_tdata;
                cnt_next   = 2'd1;
            end
            else
            begin
                pend1_next = s_tdata;
                cnt_next   = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 8'd0;
            pend1_reg <= 8'd0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            pend0_reg <= pend0_next;
            pend1_reg <= pend1_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/b64e_queue.sv
// Short group queue between the front and back parts.
module b64e_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    input  b64e_pkg::group_t          push_group,
    output logic                      full,
    input  logic                      pop,
    output logic                      not_empty,
    output b64e_pkg::group_t          head_group
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64e_pkg::group_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign not_empty  = (cnt_reg != '0);
    assign head_group = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming group
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

// File: rtl/b64e_back.sv
// Back part: four characters per queued group, one per cycle unless stalled.
module b64e_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  b64e_pkg::group_t   q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_char
    output logic               m_tlast    // end_of_message
);

    b64e_pkg::group_t cur_reg;
    b64e_pkg::group_t cur_next;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_char_reg;
    logic [7:0]       out_char_next;
    logic             out_last_reg;
    logic             out_last_next;
    logic             load_out;
    logic             emit;
    logic             group_done;
    logic [5:0]       sextet;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    // Output register frees up when empty or taken this cycle
    assign load_out   = !out_valid_reg || m_tready;
    assign emit       = load_out && cur_valid_reg;
    assign group_done = emit && (idx_reg == b64e_pkg::LAST_CHAR_IDX);
    assign q_pop      = !cur_valid_reg || group_done;

    // Pick the sextet for the current character
    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = cur_reg.b0[7:2];
            2'd1:    sextet = {cur_reg.b0[1:0], cur_reg.b1[7:4]};
            2'd2:    sextet = {cur_reg.b1[3:0], cur_reg.b2[7:6]};
            default: sextet = cur_reg.b2[5:0];
        endcase
    end

    // Form the next output character and advance through the group
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load_out)
        begin
            out_valid_next = cur_valid_reg;
        end
        if (emit)
        begin
            out_char_next = (idx_reg > cur_reg.nbytes) ? b64e_pkg::PAD_CHAR :
                            b64e_pkg::sextet_to_char(sextet);
            out_last_next = cur_reg.last_group &&
                            (idx_reg == b64e_pkg::LAST_CHAR_IDX);
            idx_next      = idx_reg + 2'd1;
        end
        if (q_pop)
        begin
            cur_next       = q_head;
            cur_valid_next = q_not_empty;
            idx_next       = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: rtl/base64_stream_encoder.sv
// Top level of the base64 stream encoder: front part, group queue, back part.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast is_final
//  m_*      out        m_tvalid/m_tready  m_tdata[7:0] out_char, m_tlast end_of_message
//
// A request is taken every cycle while the group queue has room; every third
// byte, or a final byte, queues one group. The back part sends one character
// per cycle while m_tready allows, four per group. A group passes from its queue
// entry to the current-group register, then its characters to the output register.
// Reset clears the pending byte count, the queue and the output valid flag.
// A stalled output holds its character; input stalls only when the queue is full.
module base64_stream_encoder
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // is_final
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_char
    output logic       m_tlast    // end_of_message
);

    logic                q_push;
    logic                q_full;
    b64e_pkg::group_t    new_group;
    b64e_pkg::group_t    head_group;
    logic                q_pop;
    logic                q_not_empty;

    // Group bytes into triples
    b64e_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_group  (new_group)
    );

    // Decouple grouping from character output
    b64e_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_group (new_group),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head_group (head_group)
    );

    // Serialise each group into four characters
    b64e_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (head_group),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule
